/* rtl/core/assert_macros.svh */
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/hbscf_pkg.sv */
// Types, constants and CRC function of the HDLC byte-stuffing framer.
`default_nettype none

package hbscf_pkg;

    localparam logic [7:0]  FLAG_RESET   = 8'h7E;
    localparam logic [7:0]  ESCAPE_RESET = 8'h7D;
    localparam logic [15:0] SEED_RESET   = 16'hFFFF;
    localparam logic [7:0]  STUFF_XOR    = 8'h20;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    localparam int QUEUE_DEPTH = 4;

    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  CFG_FLAG     = 2'd0;
    localparam logic [1:0]  CFG_ESCAPE   = 2'd1;
    localparam logic [1:0]  CFG_SEED     = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
        logic       empty_frame;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_done;
    } t_out;

    typedef struct packed {
        logic [7:0]  flag_value;
        logic [7:0]  escape_value;
        logic [15:0] crc_seed;
    } t_cfg;

    // One classified request handed from front to back.
    typedef struct packed {
        logic        open;
        logic        has_data;
        logic [7:0]  data;
        logic        tail;
        logic [15:0] crc;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_START,
        PH_OPEN,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_CLOSE
    } t_phase;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (v[15]) begin
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[14:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hbscf_queue.sv */
// Small register FIFO between framer front and back.
`default_nettype none
`include "assert_macros.svh"

module hbscf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "queue overflow")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "queue underflow")

endmodule

`default_nettype wire

/* rtl/core/hbscf_front.sv */
// Framer front: accepts payload requests, tracks frame state and CRC, classifies.
`default_nettype none

module hbscf_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hbscf_pkg::t_cfg i_cfg,
    input  wire logic            i_valid,
    input  wire hbscf_pkg::t_in  i_data,
    input  wire logic            i_full,
    output logic                 o_stall,
    output logic                 o_push,
    output hbscf_pkg::t_cmd      o_cmd
);

    logic        r_inside, n_inside;
    logic [15:0] r_crc, n_crc;
    logic [15:0] base_crc;
    logic [15:0] next_crc;

    assign o_stall  = i_full;
    assign o_push   = i_valid && !i_full;
    assign base_crc = r_inside ? r_crc : i_cfg.crc_seed;
    assign next_crc = hbscf_pkg::crc_byte(base_crc, i_data.data_byte);

    always_comb begin
        o_cmd.open     = i_data.empty_frame || !r_inside;
        o_cmd.has_data = !i_data.empty_frame;
        o_cmd.data     = i_data.data_byte;
        o_cmd.tail     = i_data.empty_frame || i_data.frame_last;
        o_cmd.crc      = i_data.empty_frame ? i_cfg.crc_seed : next_crc;
    end

    always_comb begin
        n_inside = r_inside;
        n_crc    = r_crc;
        if (o_push) begin
            if (o_cmd.tail) begin
                n_inside = 1'b0;
                n_crc    = i_cfg.crc_seed;
            end else begin
                n_inside = 1'b1;
                n_crc    = next_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_crc    <= hbscf_pkg::SEED_RESET;
        end else begin
            r_inside <= n_inside;
            r_crc    <= n_crc;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/hbscf_back.sv */
// Framer back: walks each request through flag, stuffed bytes, CRC and closing flag.
`default_nettype none
`include "assert_macros.svh"

module hbscf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hbscf_pkg::t_cfg i_cfg,
    input  wire hbscf_pkg::t_cmd i_cmd,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    output hbscf_pkg::t_out      o_data,
    input  wire logic            i_stall
);

    hbscf_pkg::t_phase r_phase, n_phase;
    hbscf_pkg::t_phase cur, next_ph;
    logic              r_esc, n_esc;
    logic              r_out_valid;
    hbscf_pkg::t_out   r_out, n_out;
    logic              fire;
    logic [7:0]        raw;
    logic              stuffable;
    logic              stuff_now;
    logic              ends;

    assign fire    = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Phase decode
    always_comb begin
        if (r_phase == hbscf_pkg::PH_START) begin
            if (i_cmd.open) begin
                cur = hbscf_pkg::PH_OPEN;
            end else begin
                cur = hbscf_pkg::PH_DATA;
            end
        end else begin
            cur = r_phase;
        end
        raw     = i_cmd.data;
        next_ph = hbscf_pkg::PH_START;
        ends    = 1'b0;
        case (cur)
            hbscf_pkg::PH_OPEN: begin
                next_ph = i_cmd.has_data ? hbscf_pkg::PH_DATA : hbscf_pkg::PH_CRC_HI;
            end
            hbscf_pkg::PH_DATA: begin
                next_ph = hbscf_pkg::PH_CRC_HI;
                ends    = !i_cmd.tail;
            end
            hbscf_pkg::PH_CRC_HI: begin
                raw     = i_cmd.crc[15:8];
                next_ph = hbscf_pkg::PH_CRC_LO;
            end
            hbscf_pkg::PH_CRC_LO: begin
                raw     = i_cmd.crc[7:0];
                next_ph = hbscf_pkg::PH_CLOSE;
            end
            hbscf_pkg::PH_CLOSE: begin
                ends = 1'b1;
            end
            default: begin
                ends = 1'b1;
            end
        endcase
        stuffable = cur inside {hbscf_pkg::PH_DATA, hbscf_pkg::PH_CRC_HI,
                                hbscf_pkg::PH_CRC_LO};
        stuff_now = stuffable && !r_esc &&
                    (raw == i_cfg.flag_value || raw == i_cfg.escape_value);
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        o_pop   = 1'b0;
        if (fire) begin
            if (stuff_now) begin
                n_esc   = 1'b1;
                n_phase = cur;
            end else begin
                n_esc = 1'b0;
                if (ends) begin
                    o_pop   = 1'b1;
                    n_phase = hbscf_pkg::PH_START;
                end else begin
                    n_phase = next_ph;
                end
            end
        end
    end

    // Outputs
    always_comb begin
        if (!stuffable) begin
            n_out.out_byte = i_cfg.flag_value;
        end else if (stuff_now) begin
            n_out.out_byte = i_cfg.escape_value;
        end else if (r_esc) begin
            n_out.out_byte = raw ^ hbscf_pkg::STUFF_XOR;
        end else begin
            n_out.out_byte = raw;
        end
        n_out.run_last   = !stuff_now && ends;
        n_out.frame_done = (cur == hbscf_pkg::PH_CLOSE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hbscf_pkg::PH_START;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    `ASSERT_AT(a_esc_phase, i_clk, i_rst_n, r_esc |-> (r_phase == hbscf_pkg::PH_DATA || r_phase == hbscf_pkg::PH_CRC_HI || r_phase == hbscf_pkg::PH_CRC_LO), "escape pending outside a stuffable phase")
    `ASSERT_AT(a_done_last, i_clk, i_rst_n, (r_out_valid && r_out.frame_done) |-> r_out.run_last, "closing flag not last of its request")

endmodule

`default_nettype wire

/* rtl/core/hdlc_byte_stuff_crc_framer_core.sv */
// Top level of the HDLC byte-stuffing CRC-16 framer.
`default_nettype none

// Accepts one payload request per cycle into a QUEUE_DEPTH-entry queue while not full,
// and sends one line byte per cycle from the back sequencer unless the output stalls.
// A request gives an opening flag if it starts a frame, its data byte (two if stuffed)
// unless it is an empty frame, and on the last byte of a frame the CRC high and low
// bytes (each one or two) and the closing flag; later requests queue up. Registers:
// 0 flag, 1 escape, 2 CRC seed (used at the next frame start); write only while idle.
module hdlc_byte_stuff_crc_framer_core #(
    parameter int QUEUE_DEPTH = hbscf_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire hbscf_pkg::t_in                 i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output hbscf_pkg::t_out                     o_out_data,
    input  wire logic                           i_out_stall,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [hbscf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data
);

    hbscf_pkg::t_cfg r_cfg;
    hbscf_pkg::t_cmd push_cmd;
    hbscf_pkg::t_cmd head_cmd;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_value   <= hbscf_pkg::FLAG_RESET;
            r_cfg.escape_value <= hbscf_pkg::ESCAPE_RESET;
            r_cfg.crc_seed     <= hbscf_pkg::SEED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hbscf_pkg::CFG_FLAG:   r_cfg.flag_value   <= i_cfg_data[7:0];
                hbscf_pkg::CFG_ESCAPE: r_cfg.escape_value <= i_cfg_data[7:0];
                hbscf_pkg::CFG_SEED:   r_cfg.crc_seed     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hbscf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    hbscf_queue #(
        .WIDTH ($bits(hbscf_pkg::t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .i_pop   (pop),
        .o_rdata (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    hbscf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire
